>>> hw/rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// Base64 encoder package
// Shared transaction types, character constants and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int          QUEUE_DEPTH = 2;
   localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [7:0]  PAD_CHAR    = 8'h3d;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_type;

   // One encoded byte's worth of characters; num holds the character count less one.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      num;
      logic            last;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] ext;
      ext = {2'b00, v};
      if (v inside {[6'd0:6'd25]}) begin
         return 8'h41 + ext;
      end else if (v inside {[6'd26:6'd51]}) begin
         return 8'h61 + ext - 8'd26;
      end else if (v inside {[6'd52:6'd61]}) begin
         return 8'h30 + ext - 8'd52;
      end else if (v == 6'd62) begin
         return 8'h2b;
      end else begin
         return 8'h2f;
      end
   endfunction

endpackage

>>> hw/rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// Streaming Base64 encoder
// Standard alphabet with '=' padding, one byte in and one character out.
// ----------------------------------------------------------------------------
// Each accepted byte produces one to four characters, and the result channel
// carries one character per cycle, while rsp_stall is low, from a registered
// output stage. A byte at the first or second place of its group yields one
// character, a byte at the third place two, and a final byte up to four; a
// steady stream therefore gives four characters per three bytes, its pace set
// by the single-character output register. A two-entry job queue lets new
// bytes be taken while earlier characters are still waiting to be delivered.
module base64_stream_encoder import b64e_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   queue_status_type q_status;
   logic             push, pop;
   job_type          push_job, head;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   b64e_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .pop     (pop),
      .head    (head),
      .q_status(q_status)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

`ifndef ASSERT_OFF
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("job queue reports empty and full together");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_status.empty)
      else $error("accepted byte left no job in the queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

>>> hw/rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts raw bytes, tracks the group position and builds character jobs.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;
   logic [7:0] b;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;
   assign b         = req.data_byte;

   always_comb begin
      push_job.chars = {4{PAD_CHAR}};
      push_job.last  = req.last_byte;
      push_job.num   = 2'd0;
      phase_in       = phase_ff;
      leftover_in    = leftover_ff;
      case (phase_ff)
         PHASE_SECOND: begin
            push_job.chars[0] = sextet_char({leftover_ff[1:0], b[7:4]});
            push_job.chars[1] = sextet_char({b[3:0], 2'b00});
            push_job.num      = req.last_byte ? 2'd2 : 2'd0;
            phase_in          = PHASE_THIRD;
            leftover_in       = b[3:0];
         end
         PHASE_THIRD: begin
            push_job.chars[0] = sextet_char({leftover_ff, b[7:6]});
            push_job.chars[1] = sextet_char(b[5:0]);
            push_job.num      = 2'd1;
            phase_in          = PHASE_FIRST;
            leftover_in       = 4'd0;
         end
         default: begin
            push_job.chars[0] = sextet_char(b[7:2]);
            push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
            push_job.num      = req.last_byte ? 2'd3 : 2'd0;
            phase_in          = PHASE_SECOND;
            leftover_in       = {2'b00, b[1:0]};
         end
      endcase
      if (req.last_byte) begin
         phase_in    = PHASE_FIRST;
         leftover_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_FIRST;
         leftover_ff <= 4'd0;
      end else if (push) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

>>> hw/rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short register queue that decouples the front end from the character output.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head,
   output queue_status_type q_status
);

   job_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head           = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Walks through each queued job and sends one character per transaction.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic [1:0] idx_ff;
   logic       load;
   logic       final_char;

   assign load       = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign final_char = (idx_ff == head.num);
   assign pop        = load && final_char;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.out_char <= head.chars[idx_ff];
         rsp_ff.out_last <= head.last && final_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            idx_ff <= final_char ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

endmodule
